// File: design/arcs_pkg.sv
// Shared types and constants for the ARP reply collect and sort block.
// No dependencies; used by arcs_cell and arp_reply_collect_sort.
package arcs_pkg;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int TOTAL_W  = 7;
    localparam int LEFT_W   = 7;
    localparam int MAX_RESULTS = 64;
    localparam int TOTAL_MAX   = 127;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] ARP_OP_REPLY  = 16'h0002;

    localparam logic CMD_FRAME  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_rec;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

endpackage

// File: design/arcs_cell.sv
// One insertion cell of the sorted host chain.
// Depends on arcs_pkg for the record and control types.
module arcs_cell (
    input  logic                i_clk,
    input  arcs_pkg::t_cell_ctl i_ctl,
    input  arcs_pkg::t_rec      i_new,
    input  arcs_pkg::t_rec      i_prev_rec,
    input  logic                i_prev_gt,
    input  logic                i_prev_valid,
    input  arcs_pkg::t_rec      i_next_rec,
    input  logic                i_valid,
    output arcs_pkg::t_rec      o_rec,
    output logic                o_gt
);

    arcs_pkg::t_rec r_rec;
    arcs_pkg::t_rec n_rec;

    // Strictly greater keeps equal IPs in arrival order.
    assign o_gt  = i_valid && (r_rec.ip > i_new.ip);
    assign o_rec = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.shift) begin
            n_rec = i_next_rec;
        end else if (i_ctl.insert) begin
            if (i_prev_gt) begin
                n_rec = i_prev_rec;
            end else if (o_gt || (!i_valid && i_prev_valid)) begin
                n_rec = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// File: design/arp_reply_collect_sort.sv
// Top level: ARP reply filter, chain of insertion cells and sorted read-out.
// A frame header is absorbed on its transfer; one transfer per cycle while o_stall is low.
// A finish command emits min(count, 64) results (one none-found result if count is 0),
// one per cycle while i_stall is low, the first once ST_EMIT is entered and the output
// register loads; new items wait during the read-out, which shifts one cell per result.
// Reset (i_rst_n low, synchronous) clears count, flags, config and output valid.
module arp_reply_collect_sort #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_frame_type,
    input  logic [15:0] i_arp_opcode,
    input  logic [31:0] i_sender_ip,
    input  logic [47:0] i_sender_mac,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_host_ip,
    output logic [47:0] o_host_mac,
    output logic [6:0]  o_host_total,
    output logic        o_is_last,
    output logic        o_none_found,
    output logic        o_overflowed
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    // Control state
    logic                        r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_stopped, n_stopped;
    logic                        r_ovf_seen, n_ovf_seen;
    logic                        r_stop_cfg;
    logic [arcs_pkg::LEFT_W-1:0] r_left, n_left;
    logic                        r_none, n_none;
    logic                        r_run_ovf, n_run_ovf;
    logic [arcs_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                        r_o_valid, n_o_valid;

    // Output payload, no reset needed
    arcs_pkg::t_rec              r_o_rec, n_o_rec;
    logic                        r_o_last, n_o_last;
    logic                        r_o_none, n_o_none;
    logic                        r_o_ovf, n_o_ovf;
    logic [arcs_pkg::TOTAL_W-1:0] r_o_total, n_o_total;

    logic in_xfer, out_free, is_reply, do_insert, do_emit;
    logic [arcs_pkg::LEFT_W-1:0] emit_cnt;
    logic [arcs_pkg::TOTAL_W-1:0] sat_total;

    arcs_pkg::t_cell_ctl ctl;
    arcs_pkg::t_rec      new_rec;
    arcs_pkg::t_rec      w_rec [TABLE_DEPTH];
    logic                w_gt  [TABLE_DEPTH];
    logic                w_vld [TABLE_DEPTH];

    // Hold off new items while the sorted list drains.
    assign o_stall  = (r_state == ST_EMIT);
    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;

    assign is_reply  = (i_cmd == arcs_pkg::CMD_FRAME) && !r_stopped &&
                       (i_frame_type == arcs_pkg::ETHERTYPE_ARP) &&
                       (i_arp_opcode == arcs_pkg::ARP_OP_REPLY);
    assign do_insert = in_xfer && is_reply && (32'(r_count) < TABLE_DEPTH);
    assign do_emit   = (r_state == ST_EMIT) && out_free;

    assign emit_cnt  = (32'(r_count) < arcs_pkg::MAX_RESULTS) ?
                       arcs_pkg::LEFT_W'(r_count) :
                       arcs_pkg::LEFT_W'(arcs_pkg::MAX_RESULTS);
    assign sat_total = (32'(r_count) > arcs_pkg::TOTAL_MAX) ?
                       arcs_pkg::TOTAL_W'(arcs_pkg::TOTAL_MAX) :
                       arcs_pkg::TOTAL_W'(r_count);

    assign new_rec.ip  = i_sender_ip;
    assign new_rec.mac = i_sender_mac;
    assign ctl.insert  = do_insert;
    // Advance the chain toward cell 0 on each emitted entry.
    assign ctl.shift   = do_emit && !r_none;

    // Chain of insertion cells; cell 0 holds the lowest IP.
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        assign w_vld[gi] = (r_count > CW'(gi));
        if (gi == 0) begin : g_head
            arcs_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_new        (new_rec),
                .i_prev_rec   ('0),
                .i_prev_gt    (1'b0),
                .i_prev_valid (1'b1),
                .i_next_rec   (w_rec[(gi+1) % TABLE_DEPTH]),
                .i_valid      (w_vld[gi]),
                .o_rec        (w_rec[gi]),
                .o_gt         (w_gt[gi])
            );
        end else if (gi == TABLE_DEPTH - 1) begin : g_tail
            arcs_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_new        (new_rec),
                .i_prev_rec   (w_rec[gi-1]),
                .i_prev_gt    (w_gt[gi-1]),
                .i_prev_valid (w_vld[gi-1]),
                .i_next_rec   ('0),
                .i_valid      (w_vld[gi]),
                .o_rec        (w_rec[gi]),
                .o_gt         (w_gt[gi])
            );
        end else begin : g_mid
            arcs_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_new        (new_rec),
                .i_prev_rec   (w_rec[gi-1]),
                .i_prev_gt    (w_gt[gi-1]),
                .i_prev_valid (w_vld[gi-1]),
                .i_next_rec   (w_rec[gi+1]),
                .i_valid      (w_vld[gi]),
                .o_rec        (w_rec[gi]),
                .o_gt         (w_gt[gi])
            );
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_stopped  = r_stopped;
        n_ovf_seen = r_ovf_seen;
        n_left     = r_left;
        n_none     = r_none;
        n_run_ovf  = r_run_ovf;
        n_total    = r_total;
        n_o_valid  = r_o_valid && i_stall;
        n_o_rec    = r_o_rec;
        n_o_last   = r_o_last;
        n_o_none   = r_o_none;
        n_o_ovf    = r_o_ovf;
        n_o_total  = r_o_total;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_cmd == arcs_pkg::CMD_FRAME) begin
                    if (do_insert) begin
                        n_count = r_count + CW'(1);
                    end else if (is_reply) begin
                        n_ovf_seen = 1'b1;   // table full: drop and flag
                    end
                    if (is_reply && r_stop_cfg) begin
                        n_stopped = 1'b1;
                    end
                end else if (in_xfer) begin
                    // Latch run summary, then start a fresh collection.
                    n_state    = ST_EMIT;
                    n_none     = (r_count == '0);
                    n_left     = (r_count == '0) ? arcs_pkg::LEFT_W'(1) : emit_cnt;
                    n_total    = sat_total;
                    n_run_ovf  = r_ovf_seen;
                    n_count    = '0;
                    n_stopped  = 1'b0;
                    n_ovf_seen = 1'b0;
                end
            end
            ST_EMIT: begin
                if (do_emit) begin
                    n_o_valid = 1'b1;
                    n_o_rec   = r_none ? '0 : w_rec[0];
                    n_o_total = r_none ? '0 : r_total;
                    n_o_none  = r_none;
                    n_o_ovf   = r_run_ovf;
                    n_o_last  = (r_left == arcs_pkg::LEFT_W'(1));
                    n_left    = r_left - arcs_pkg::LEFT_W'(1);
                    if (r_left == arcs_pkg::LEFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_stopped  <= 1'b0;
            r_ovf_seen <= 1'b0;
            r_stop_cfg <= 1'b0;
            r_left     <= '0;
            r_none     <= 1'b0;
            r_run_ovf  <= 1'b0;
            r_total    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_stopped  <= n_stopped;
            r_ovf_seen <= n_ovf_seen;
            if (i_cfg_we) begin
                r_stop_cfg <= i_cfg_data;
            end
            r_left     <= n_left;
            r_none     <= n_none;
            r_run_ovf  <= n_run_ovf;
            r_total    <= n_total;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_rec   <= n_o_rec;
        r_o_last  <= n_o_last;
        r_o_none  <= n_o_none;
        r_o_ovf   <= n_o_ovf;
        r_o_total <= n_o_total;
    end

    assign o_valid      = r_o_valid;
    assign o_host_ip    = r_o_rec.ip;
    assign o_host_mac   = r_o_rec.mac;
    assign o_host_total = r_o_total;
    assign o_is_last    = r_o_last;
    assign o_none_found = r_o_none;
    assign o_overflowed = r_o_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= TABLE_DEPTH)
        else $error("entry count beyond table depth");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_none_found) |-> o_is_last)
        else $error("empty-table result not marked last");

    a_finish_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_cmd == arcs_pkg::CMD_FINISH) |=> (r_state == ST_EMIT && r_count == '0))
        else $error("finish did not start read-out");

    // The next result of a run follows right behind a transfer that was not the last.
    a_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_is_last) |=> o_valid)
        else $error("read-out paused before last result");

endmodule
